// ----- src/wheel_pedal_drive_command_mapper_top_assert.svh -----
// Assertion macros for the wheel and pedal drive command mapper.
`ifndef WHEEL_PEDAL_DRIVE_COMMAND_MAPPER_TOP_ASSERT_SVH
`define WHEEL_PEDAL_DRIVE_COMMAND_MAPPER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define WPDM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define WPDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/wpdm_pkg.sv -----
// Shared types and constants for the drive command mapper.
package wpdm_pkg;

    localparam int FIELD_AXES    = 6;
    localparam int FIELD_BUTTONS = 8;
    localparam int AXIS_W        = 16;
    localparam int VEL_W         = 32;
    localparam int MUL_A_W       = 32;
    localparam int MUL_B_W       = 17;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;

    typedef logic [FIELD_AXES-1:0][AXIS_W-1:0] t_axes;

    localparam logic [1:0] GEAR_INVALID = 2'd0;
    localparam logic [1:0] GEAR_FORWARD = 2'd1;
    localparam logic [1:0] GEAR_REVERSE = 2'd2;

    localparam logic [2:0] REG_AXIS_MAP      = 3'd0;
    localparam logic [2:0] REG_TURBO_BUTTON  = 3'd1;
    localparam logic [2:0] REG_LINEAR_SCALE  = 3'd2;
    localparam logic [2:0] REG_ANGULAR_SCALE = 3'd3;
    localparam logic [2:0] REG_TURBO_SCALE   = 3'd4;
    localparam logic [2:0] REG_TURBO_ALLOWED = 3'd5;
    localparam logic [2:0] REG_DEADMAN_REQ   = 3'd6;

    typedef struct packed {
        logic [11:0] axis_map;
        logic [2:0]  turbo_button;
        logic [15:0] linear_scale;
        logic [15:0] angular_scale;
        logic [11:0] turbo_scale;
        logic        turbo_allowed;
        logic        deadman_required;
    } t_cfg;

    typedef enum logic [1:0] {
        MUL_BRAKE,
        MUL_STEER,
        MUL_THROTTLE,
        MUL_TURBO
    } t_mul_op;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_BRAKE,
        KIND_DRIVE
    } t_kind;

    typedef struct packed {
        logic    capture;
        logic    gear_upd;
        logic    prod_load;
        t_mul_op mul_op;
        logic    ang_load;
        logic    commit;
        t_kind   kind;
    } t_cmd;

    typedef struct packed {
        logic dead_block;
        logic brake_on;
        logic turbo_on;
        logic out_free;
    } t_stat;

endpackage

// ----- src/wpdm_cfg.sv -----
// Configuration register file for the drive command mapper.
module wpdm_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output wpdm_pkg::t_cfg    o_cfg
);
    import wpdm_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis_map         <= 12'd1672;
            r_cfg.turbo_button     <= 3'd1;
            r_cfg.linear_scale     <= 16'd256;
            r_cfg.angular_scale    <= 16'd256;
            r_cfg.turbo_scale      <= 12'd384;
            r_cfg.turbo_allowed    <= 1'b0;
            r_cfg.deadman_required <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_AXIS_MAP:      r_cfg.axis_map         <= i_cfg_data[11:0];
                REG_TURBO_BUTTON:  r_cfg.turbo_button     <= i_cfg_data[2:0];
                REG_LINEAR_SCALE:  r_cfg.linear_scale     <= i_cfg_data;
                REG_ANGULAR_SCALE: r_cfg.angular_scale    <= i_cfg_data;
                REG_TURBO_SCALE:   r_cfg.turbo_scale      <= i_cfg_data[11:0];
                REG_TURBO_ALLOWED: r_cfg.turbo_allowed    <= i_cfg_data[0];
                REG_DEADMAN_REQ:   r_cfg.deadman_required <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

// ----- src/wpdm_ctrl.sv -----
// Sequencing state machine for the drive command mapper.
module wpdm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  wpdm_pkg::t_stat i_stat,
    output wpdm_pkg::t_cmd  o_cmd
);
    import wpdm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_BRAKE,
        S_STEER,
        S_THR,
        S_TURBO,
        S_WRITE
    } t_state;

    t_state r_state, n_state;
    t_kind  r_kind,  n_kind;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '{capture: 1'b0, gear_upd: 1'b0, prod_load: 1'b0, mul_op: MUL_BRAKE,
                    ang_load: 1'b0, commit: 1'b0, kind: r_kind};
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_stat.dead_block) begin
                    n_kind  = KIND_ZERO;
                    n_state = S_WRITE;
                end else begin
                    o_cmd.gear_upd = 1'b1;
                    if (i_stat.brake_on) begin
                        n_kind  = KIND_BRAKE;
                        n_state = S_BRAKE;
                    end else begin
                        n_kind  = KIND_DRIVE;
                        n_state = S_STEER;
                    end
                end
            end
            S_BRAKE: begin
                o_cmd.mul_op    = MUL_BRAKE;
                o_cmd.prod_load = 1'b1;
                n_state         = S_WRITE;
            end
            S_STEER: begin
                o_cmd.mul_op    = MUL_STEER;
                o_cmd.prod_load = 1'b1;
                n_state         = S_THR;
            end
            S_THR: begin
                // steering product is taken before the throttle product lands
                o_cmd.ang_load  = 1'b1;
                o_cmd.mul_op    = MUL_THROTTLE;
                o_cmd.prod_load = 1'b1;
                n_state         = i_stat.turbo_on ? S_TURBO : S_WRITE;
            end
            S_TURBO: begin
                o_cmd.mul_op    = MUL_TURBO;
                o_cmd.prod_load = 1'b1;
                n_state         = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.commit = i_stat.out_free;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_ZERO;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

// ----- src/wpdm_datapath.sv -----
// Datapath: captured report, gear state, shared multiplier, held commands, output register.
module wpdm_datapath #(
    parameter int NUM_AXES       = 6,
    parameter int NUM_BUTTONS    = 8,
    parameter int FORWARD_BUTTON = 0,
    parameter int REVERSE_BUTTON = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wpdm_pkg::t_cfg        i_cfg,
    input  wpdm_pkg::t_cmd        i_cmd,
    output wpdm_pkg::t_stat       o_stat,
    input  wpdm_pkg::t_axes       i_axes,
    input  logic [2:0]            i_axis_count,
    input  logic [7:0]            i_button_bits,
    input  logic [3:0]            i_button_count,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [31:0]           o_linear_velocity,
    output logic [31:0]           o_angular_velocity,
    output logic [1:0]            o_gear
);
    import wpdm_pkg::*;

    localparam int AXIS_LIM = (NUM_AXES < FIELD_AXES) ? NUM_AXES : FIELD_AXES;
    localparam int BTN_LIM  = (NUM_BUTTONS < FIELD_BUTTONS) ? NUM_BUTTONS : FIELD_BUTTONS;
    localparam logic [2:0] FWD_IDX = 3'(FORWARD_BUTTON);
    localparam logic [2:0] REV_IDX = 3'(REVERSE_BUTTON);

    // captured report
    t_axes       r_axes;
    logic [2:0]  r_axis_cnt;
    logic [7:0]  r_btn;
    logic [3:0]  r_btn_cnt;

    // block state
    logic [1:0]  r_gear, n_gear;
    logic        r_prev_fwd, n_prev_fwd;
    logic        r_prev_rev, n_prev_rev;
    logic [VEL_W-1:0] r_held_lin, n_held_lin;
    logic [VEL_W-1:0] r_held_ang, n_held_ang;

    logic [PROD_W-1:0] r_prod;
    logic [VEL_W-1:0]  r_ang_res;

    logic              r_out_valid;
    logic [VEL_W-1:0]  r_out_lin;
    logic [VEL_W-1:0]  r_out_ang;
    logic [1:0]        r_out_gear;

    logic [2:0]  steer_sel, dead_sel, thr_sel, brk_sel;
    logic        steer_ok, dead_ok, thr_ok, brk_ok;
    logic [AXIS_W-1:0] steer_raw, dead_raw, thr_raw, brk_raw;
    logic [AXIS_W-1:0] thr_ped, brk_ped, steer_mag;
    logic        steer_neg;
    logic [18:0] brk_x5;
    logic        fwd_ok, rev_ok, turbo_ok;
    logic        fwd_lvl, rev_lvl, fwd_rel, rev_rel;
    logic        gear_valid;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic        held_neg;
    logic [VEL_W-1:0]   held_mag;

    logic [PROD_W-1:0] rnd7, rnd8, rnd16;
    logic [VEL_W-1:0]  ang_mag, lin_mag;

    function automatic logic [AXIS_W-1:0] axis_pick(input t_axes axes, input logic [2:0] sel);
        logic [AXIS_W-1:0] v;
        case (sel)
            3'd0:    v = axes[0];
            3'd1:    v = axes[1];
            3'd2:    v = axes[2];
            3'd3:    v = axes[3];
            3'd4:    v = axes[4];
            3'd5:    v = axes[5];
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic axis_ok(input logic [2:0] sel, input logic [2:0] cnt);
        return (sel < cnt) && (4'(sel) < 4'(AXIS_LIM));
    endfunction

    function automatic logic btn_ok(input logic [2:0] idx, input logic [3:0] cnt);
        return ({1'b0, idx} < cnt) && (5'(idx) < 5'(BTN_LIM));
    endfunction

    function automatic logic [VEL_W-1:0] with_sign(input logic [VEL_W-1:0] mag,
                                                   input logic neg);
        return neg ? (VEL_W'(0) - mag) : mag;
    endfunction

    // axis selection and pedal mapping (raw + 32768 is a flip of the top bit)
    always_comb begin
        steer_sel = i_cfg.axis_map[2:0];
        dead_sel  = i_cfg.axis_map[5:3];
        thr_sel   = i_cfg.axis_map[8:6];
        brk_sel   = i_cfg.axis_map[11:9];
        steer_ok  = axis_ok(steer_sel, r_axis_cnt);
        dead_ok   = axis_ok(dead_sel, r_axis_cnt);
        thr_ok    = axis_ok(thr_sel, r_axis_cnt);
        brk_ok    = axis_ok(brk_sel, r_axis_cnt);
        steer_raw = axis_pick(r_axes, steer_sel);
        dead_raw  = axis_pick(r_axes, dead_sel);
        thr_raw   = axis_pick(r_axes, thr_sel);
        brk_raw   = axis_pick(r_axes, brk_sel);
        thr_ped   = thr_ok ? (thr_raw ^ 16'h8000) : '0;
        brk_ped   = brk_ok ? (brk_raw ^ 16'h8000) : '0;
        steer_neg = steer_ok && steer_raw[AXIS_W-1];
        steer_mag = !steer_ok ? '0 : (steer_neg ? (16'(0) - steer_raw) : steer_raw);
        brk_x5    = {1'b0, brk_ped, 2'b00} + {3'b000, brk_ped};
    end

    // gear update on button release; gear invalid while a gear button is out of range
    always_comb begin
        fwd_ok     = (FORWARD_BUTTON < BTN_LIM) && btn_ok(FWD_IDX, r_btn_cnt);
        rev_ok     = (REVERSE_BUTTON < BTN_LIM) && btn_ok(REV_IDX, r_btn_cnt);
        fwd_lvl    = r_btn[FWD_IDX];
        rev_lvl    = r_btn[REV_IDX];
        fwd_rel    = !fwd_lvl && r_prev_fwd;
        rev_rel    = !rev_lvl && r_prev_rev;
        n_gear     = r_gear;
        n_prev_fwd = r_prev_fwd;
        n_prev_rev = r_prev_rev;
        if (!(fwd_ok && rev_ok)) begin
            n_gear = GEAR_INVALID;
        end else begin
            case (r_gear)
                GEAR_FORWARD: if (rev_rel) n_gear = GEAR_REVERSE;
                GEAR_REVERSE: if (fwd_rel) n_gear = GEAR_FORWARD;
                default: begin
                    if (fwd_rel)      n_gear = GEAR_FORWARD;
                    else if (rev_rel) n_gear = GEAR_REVERSE;
                    else              n_gear = GEAR_INVALID;
                end
            endcase
            n_prev_fwd = fwd_lvl;
            n_prev_rev = rev_lvl;
        end
    end

    assign turbo_ok = i_cfg.turbo_allowed && btn_ok(i_cfg.turbo_button, r_btn_cnt)
                      && r_btn[i_cfg.turbo_button];

    assign o_stat.dead_block = i_cfg.deadman_required && (!dead_ok || dead_raw == 16'h8000);
    assign o_stat.brake_on   = brk_x5 > 19'd65536;
    assign o_stat.turbo_on   = turbo_ok;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // shared multiplier operand select
    assign held_neg = r_held_lin[VEL_W-1];
    assign held_mag = held_neg ? (VEL_W'(0) - r_held_lin) : r_held_lin;

    always_comb begin
        case (i_cmd.mul_op)
            MUL_BRAKE: begin
                mul_a = held_mag;
                mul_b = 17'h10000 - {1'b0, brk_ped};
            end
            MUL_STEER: begin
                mul_a = {16'd0, steer_mag};
                mul_b = {1'b0, i_cfg.angular_scale};
            end
            MUL_THROTTLE: begin
                mul_a = {16'd0, thr_ped};
                mul_b = {1'b0, i_cfg.linear_scale};
            end
            MUL_TURBO: begin
                mul_a = r_prod[MUL_A_W-1:0];
                mul_b = {5'd0, i_cfg.turbo_scale};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round to nearest, halves away from zero on magnitudes
    assign rnd7    = r_prod + PROD_W'(64);
    assign rnd8    = r_prod + PROD_W'(128);
    assign rnd16   = r_prod + PROD_W'(32768);
    assign ang_mag = rnd7[VEL_W+6:7];
    assign lin_mag = (i_cmd.kind == KIND_DRIVE && !turbo_ok) ? rnd8[VEL_W+7:8]
                                                             : rnd16[VEL_W+15:16];
    assign gear_valid = (r_gear == GEAR_FORWARD) || (r_gear == GEAR_REVERSE);

    always_comb begin
        n_held_lin = r_held_lin;
        n_held_ang = r_held_ang;
        case (i_cmd.kind)
            KIND_ZERO: begin
                n_held_lin = '0;
                n_held_ang = '0;
            end
            KIND_BRAKE: begin
                n_held_lin = gear_valid ? with_sign(lin_mag, held_neg) : '0;
            end
            KIND_DRIVE: begin
                n_held_ang = r_ang_res;
                n_held_lin = gear_valid ? with_sign(lin_mag, r_gear == GEAR_REVERSE) : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_axes     <= i_axes;
            r_axis_cnt <= i_axis_count;
            r_btn      <= i_button_bits;
            r_btn_cnt  <= i_button_count;
        end
        if (i_cmd.prod_load) r_prod <= PROD_W'(mul_a * mul_b);
        if (i_cmd.ang_load)  r_ang_res <= with_sign(ang_mag, steer_neg);
        if (i_cmd.commit) begin
            r_out_lin  <= n_held_lin;
            r_out_ang  <= n_held_ang;
            r_out_gear <= r_gear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear      <= GEAR_FORWARD;
            r_prev_fwd  <= 1'b0;
            r_prev_rev  <= 1'b0;
            r_held_lin  <= '0;
            r_held_ang  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.gear_upd) begin
                r_gear     <= n_gear;
                r_prev_fwd <= n_prev_fwd;
                r_prev_rev <= n_prev_rev;
            end
            if (i_cmd.commit) begin
                r_held_lin  <= n_held_lin;
                r_held_ang  <= n_held_ang;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_linear_velocity  = r_out_lin;
    assign o_angular_velocity = r_out_ang;
    assign o_gear             = r_out_gear;

endmodule

// ----- src/wheel_pedal_drive_command_mapper_top.sv -----
// Wheel and pedal drive command mapper: top level with stream ports and config port.
//
// Input stream (s_axis): one wheel/pedal report per transaction. The block
// keeps the gear and the held velocity pair between reports and returns
// exactly one result transaction (m_axis) per report: linear and angular
// velocity in signed Q16.16 and the gear after this report.
// Config port: one register write per transaction (index, data); always ready.
// The user must write registers only while no report is in flight; the
// block itself does not enforce this. The shared 32x17 multiplier runs one
// product per cycle; the next report is taken only after the result is
// loaded into the output register, so a new report is not accepted while
// one is in flight.
// The result sits in an output register: a stalled receiver does not block
// the next report from being accepted and worked, it only holds the final
// write step until the register is free.
// Reset (i_rst_n low, synchronous): config registers to defaults, gear to
// forward, held commands and button history to zero, no result pending.
`include "wheel_pedal_drive_command_mapper_top_assert.svh"

module wheel_pedal_drive_command_mapper_top #(
    parameter int NUM_AXES       = 6,
    parameter int NUM_BUTTONS    = 8,
    parameter int FORWARD_BUTTON = 0,
    parameter int REVERSE_BUTTON = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // report in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // axis_0 .. axis_5 [95:0], axis_count [98:96], button_bits [106:99],
    // button_count [110:107], zero pad [111]
    input  logic [111:0] s_axis_tdata,
    // command out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // linear_velocity [31:0], angular_velocity [63:32], gear [65:64], zero pad [71:66]
    output logic [71:0]  m_axis_tdata,
    // config write
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    import wpdm_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    logic [31:0] out_lin;
    logic [31:0] out_ang;
    logic [1:0]  out_gear;

    wpdm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // controller: walks one report through eval, multiply steps and write
    wpdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wpdm_datapath #(
        .NUM_AXES       (NUM_AXES),
        .NUM_BUTTONS    (NUM_BUTTONS),
        .FORWARD_BUTTON (FORWARD_BUTTON),
        .REVERSE_BUTTON (REVERSE_BUTTON)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_axes             (s_axis_tdata[95:0]),
        .i_axis_count       (s_axis_tdata[98:96]),
        .i_button_bits      (s_axis_tdata[106:99]),
        .i_button_count     (s_axis_tdata[110:107]),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_linear_velocity  (out_lin),
        .o_angular_velocity (out_ang),
        .o_gear             (out_gear)
    );

    assign m_axis_tdata = {6'd0, out_gear, out_ang, out_lin};

    // a report in flight blocks the next one
    `WPDM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "report accepted while another is in flight")
    // ready drops only on a transaction
    `WPDM_ASSERT_SAME(a_ready_drop_on_accept, i_clk, i_rst_n, $fell(s_axis_tready), $past(s_axis_tvalid), "input ready dropped without a transaction")
    // gear code three never leaves the block
    `WPDM_ASSERT_SAME(a_gear_code_legal, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[65:64] != 2'd3, "illegal gear code on output")

endmodule

// ----- tb/sv/wheel_pedal_drive_command_mapper_top_tb.sv -----
// Self-checking testbench for the wheel and pedal drive command mapper top level.
`timescale 1ns / 100ps

module wheel_pedal_drive_command_mapper_top_tb;
    import wpdm_pkg::*;

    // DUT build under test; the predictor uses the same values
    localparam int NUM_AXES       = 6;
    localparam int NUM_BUTTONS    = 8;
    localparam int FORWARD_BUTTON = 0;
    localparam int REVERSE_BUTTON = 3;

    // no register behind this index, writes to it must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd7;

    localparam int ITEMS_PER_PHASE = 125;
    localparam int RANDOM_PHASES   = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 12;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_PRINTED     = 40;

    typedef struct packed {
        logic [31:0] linear;
        logic [31:0] angular;
        logic [1:0]  gear;
    } drive_cmd_t;

    // Predicts the command pair and gear for every accepted report and checks
    // each result transaction against the oldest prediction.
    class drive_cmd_scoreboard;
        t_cfg               cfg;
        logic [1:0]         gear;
        bit                 prev_fwd;
        bit                 prev_rev;
        logic signed [31:0] held_linear;
        logic signed [31:0] held_angular;
        drive_cmd_t         pending_cmds [$];
        int                 mismatches;

        // decoded fields of the report being worked
        t_axes              report_axes;
        int                 valid_axes;
        int                 valid_buttons;
        logic [7:0]         button_now;

        function new();
            cfg           = '{axis_map: 12'd1672, turbo_button: 3'd1, linear_scale: 16'd256,
                              angular_scale: 16'd256, turbo_scale: 12'd384,
                              turbo_allowed: 1'b0, deadman_required: 1'b0};
            gear          = GEAR_FORWARD;
            prev_fwd      = 1'b0;
            prev_rev      = 1'b0;
            held_linear   = '0;
            held_angular  = '0;
            mismatches    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_AXIS_MAP:      cfg.axis_map         = data[11:0];
                REG_TURBO_BUTTON:  cfg.turbo_button     = data[2:0];
                REG_LINEAR_SCALE:  cfg.linear_scale     = data;
                REG_ANGULAR_SCALE: cfg.angular_scale    = data;
                REG_TURBO_SCALE:   cfg.turbo_scale      = data[11:0];
                REG_TURBO_ALLOWED: cfg.turbo_allowed    = data[0];
                REG_DEADMAN_REQ:   cfg.deadman_required = data[0];
                default: ;
            endcase
        endfunction

        // |v| * k rounded to nearest at bit s, halves away from zero, sign put back
        function longint mul_round(longint v, longint k, int s);
            longint m;
            bit     neg;
            neg = v < 0;
            m   = neg ? -v : v;
            m   = (m * k + (longint'(1) << (s - 1))) >> s;
            return neg ? -m : m;
        endfunction

        // pedal position 0..65535 (of 65536); an axis past the valid count reads 0
        function longint pedal_level(logic [2:0] sel);
            if (int'(sel) >= valid_axes)
                return 0;
            return longint'({~report_axes[sel][15], report_axes[sel][14:0]});
        endfunction

        function void advance_gear();
            bit fwd;
            bit rev;
            bit fwd_rel;
            bit rev_rel;
            if (FORWARD_BUTTON >= valid_buttons || REVERSE_BUTTON >= valid_buttons) begin
                gear = GEAR_INVALID;
                return;
            end
            fwd     = button_now[FORWARD_BUTTON];
            rev     = button_now[REVERSE_BUTTON];
            fwd_rel = !fwd && prev_fwd;
            rev_rel = !rev && prev_rev;
            case (gear)
                GEAR_FORWARD: if (rev_rel) gear = GEAR_REVERSE;
                GEAR_REVERSE: if (fwd_rel) gear = GEAR_FORWARD;
                default: begin
                    // forward release wins when both go at once
                    gear = fwd_rel ? GEAR_FORWARD : (rev_rel ? GEAR_REVERSE : GEAR_INVALID);
                end
            endcase
            prev_fwd = fwd;
            prev_rev = rev;
        endfunction

        function void note_report(logic [111:0] d);
            drive_cmd_t cmd;
            longint     a;
            longint     mag;
            logic [2:0] steer_sel;
            report_axes   = d[95:0];
            valid_axes    = (int'(d[98:96]) > NUM_AXES) ? NUM_AXES : int'(d[98:96]);
            button_now    = d[106:99];
            valid_buttons = (int'(d[110:107]) > NUM_BUTTONS) ? NUM_BUTTONS : int'(d[110:107]);
            steer_sel     = cfg.axis_map[2:0];

            if (cfg.deadman_required && pedal_level(cfg.axis_map[5:3]) == 0) begin
                // deadman gate: gear and button history untouched
                held_linear  = '0;
                held_angular = '0;
            end else begin
                advance_gear();
                a = pedal_level(cfg.axis_map[11:9]);
                if (a * 5 > 65536) begin
                    // brake: scale the held speed, angular kept
                    if (gear == GEAR_FORWARD || gear == GEAR_REVERSE)
                        held_linear = 32'(mul_round(longint'(held_linear), 65536 - a, 16));
                    else
                        held_linear = '0;
                end else begin
                    if (int'(steer_sel) < valid_axes)
                        held_angular = 32'(mul_round(longint'($signed(report_axes[steer_sel])),
                                                     longint'(cfg.angular_scale), 7));
                    else
                        held_angular = '0;
                    mag = pedal_level(cfg.axis_map[8:6]) * longint'(cfg.linear_scale);
                    if (cfg.turbo_allowed && int'(cfg.turbo_button) < valid_buttons
                            && button_now[cfg.turbo_button])
                        mag = mul_round(mag, longint'(cfg.turbo_scale), 16);
                    else
                        mag = mul_round(mag, 1, 8);
                    case (gear)
                        GEAR_FORWARD: held_linear = 32'(mag);
                        GEAR_REVERSE: held_linear = 32'(-mag);
                        default:      held_linear = '0;
                    endcase
                end
            end
            cmd = '{linear: held_linear, angular: held_angular, gear: gear};
            pending_cmds.push_back(cmd);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic [71:0] d);
            drive_cmd_t want;
            if (pending_cmds.size() == 0) begin
                report_mismatch($sformatf("result %h with no pending command", d));
                return;
            end
            want = pending_cmds.pop_front();
            if (d[31:0] !== want.linear)
                report_mismatch($sformatf("linear_velocity got %h want %h", d[31:0], want.linear));
            if (d[63:32] !== want.angular)
                report_mismatch($sformatf("angular_velocity got %h want %h",
                                          d[63:32], want.angular));
            if (d[65:64] !== want.gear)
                report_mismatch($sformatf("gear got %0d want %0d", d[65:64], want.gear));
        endtask
    endclass

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // axis_0..axis_5 [95:0], axis_count [98:96], button_bits [106:99],
    // button_count [110:107], pad [111]
    logic [111:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // linear_velocity [31:0], angular_velocity [63:32], gear [65:64], pad [71:66]
    logic [71:0]  m_axis_tdata;
    logic         i_cfg_valid   = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index   = '0;
    logic [15:0]  i_cfg_data    = '0;

    // traffic shaping, all written only with nonblocking assignments
    logic         gaps_on       = 1'b1;
    logic         hold_off      = 1'b0;
    int           sink_idle     = 0;

    drive_cmd_scoreboard sb = new();

    wheel_pedal_drive_command_mapper_top #(
        .NUM_AXES       (NUM_AXES),
        .NUM_BUTTONS    (NUM_BUTTONS),
        .FORWARD_BUTTON (FORWARD_BUTTON),
        .REVERSE_BUTTON (REVERSE_BUTTON)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side: check every result transaction, then pick next tready.
    // The long hold-off wins over everything; otherwise short idle bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (sink_idle != 0) begin
            m_axis_tready <= 1'b0;
            sink_idle     <= sink_idle - 1;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            sink_idle     <= $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: ends the run once no transaction of any kind has gone
    // through for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("wheel_pedal_drive_command_mapper_top_tb: FAIL");
        $finish;
    end

    // Called at a clock edge; leaves tvalid high so back-to-back reports
    // need no second assignment in one step.
    task automatic send_report(t_axes ax, logic [2:0] n_axes, logic [7:0] btn,
                               logic [3:0] n_btn);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, n_btn, btn, n_axes, ax};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_report(s_axis_tdata);
    endtask

    // Mostly well-formed reports: all axes valid, buttons usually all valid,
    // deadman usually held, brake usually off so the drive path gets exercised.
    // The rest is noise with any axis and button counts.
    task automatic send_random_report();
        t_axes      ax;
        logic [2:0] n_axes;
        logic [7:0] btn;
        logic [3:0] n_btn;
        logic [2:0] dead_sel;
        logic [2:0] brk_sel;
        dead_sel = sb.cfg.axis_map[5:3];
        brk_sel  = sb.cfg.axis_map[11:9];
        for (int i = 0; i < FIELD_AXES; i++) begin
            case ($urandom_range(0, 7))
                0:       ax[i] = 16'h8000;
                1:       ax[i] = 16'h7FFF;
                2:       ax[i] = 16'h0000;
                3:       ax[i] = 16'hFFFF;
                default: ax[i] = 16'($urandom);
            endcase
        end
        btn = 8'($urandom);
        if ($urandom_range(0, 99) < 15) begin
            n_axes = 3'($urandom);
            n_btn  = 4'($urandom);
        end else begin
            n_axes = 3'(FIELD_AXES);
            n_btn  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(4, 7)) : 4'(FIELD_BUTTONS);
            if (int'(dead_sel) < FIELD_AXES && ax[dead_sel] == 16'h8000
                    && $urandom_range(0, 3) != 0)
                ax[dead_sel] = 16'h8001;
            // pedal at or below 0.2 leaves the brake off
            if (int'(brk_sel) < FIELD_AXES && $urandom_range(0, 9) < 7)
                ax[brk_sel] = 16'h8000 + 16'($urandom_range(0, 13107));
        end
        send_report(ax, n_axes, btn, n_btn);
    endtask

    // One config transaction; i_cfg_valid is lowered by the caller after the last.
    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // Unused upper data bits carry noise; the block must ignore them.
    function automatic logic [15:0] with_noise(logic [15:0] value, int w);
        logic [15:0] keep;
        keep = 16'((32'd1 << w) - 1);
        return (16'($urandom) & ~keep) | (value & keep);
    endfunction

    task automatic apply_cfg(t_cfg c);
        write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_AXIS_MAP,      with_noise(16'(c.axis_map), 12));
        write_reg(REG_TURBO_BUTTON,  with_noise(16'(c.turbo_button), 3));
        write_reg(REG_LINEAR_SCALE,  c.linear_scale);
        write_reg(REG_ANGULAR_SCALE, c.angular_scale);
        write_reg(REG_TURBO_SCALE,   with_noise(16'(c.turbo_scale), 12));
        write_reg(REG_TURBO_ALLOWED, with_noise(16'(c.turbo_allowed), 1));
        write_reg(REG_DEADMAN_REQ,   with_noise(16'(c.deadman_required), 1));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_gain(int w);
        logic [15:0] top;
        top = 16'((32'd1 << w) - 1);
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return top;
            2:       return 16'd256;
            default: return 16'($urandom) & top;
        endcase
    endfunction

    function automatic logic [11:0] rand_axis_map();
        logic [11:0] m;
        for (int k = 0; k < 4; k++)
            m[3*k +: 3] = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                      : 3'($urandom_range(0, 5));
        return m;
    endfunction

    // Config writes only happen with nothing in flight: every report gives
    // exactly one result, so an empty expectation queue means idle.
    task automatic wait_drained();
        while (sb.pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_cfg c;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed, reset config: steer a0, deadman a1, throttle a2, brake a3
        // axes listed a5 first
        // full throttle and steer, then both at minimum
        send_report({16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF}, 3'd6, 8'h00, 4'd8);
        send_report({16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000}, 3'd6, 8'h00, 4'd8);
        // reverse press, then release: into reverse, throttle sign flips
        send_report({16'h0000, 16'h0000, 16'h8000, 16'h4000, 16'h0000, 16'h1234}, 3'd6, 8'h08, 4'd8);
        send_report({16'h0000, 16'h0000, 16'h8000, 16'h4000, 16'h0000, 16'hEDCC}, 3'd6, 8'h00, 4'd8);
        // brake exactly at 0.2 is still off; forward held
        send_report({16'h0000, 16'h0000, 16'hB333, 16'h7FFF, 16'h0000, 16'h5555}, 3'd6, 8'h01, 4'd8);
        // brake just above 0.2 with forward release in the same report
        send_report({16'h0000, 16'h0000, 16'hB334, 16'h7FFF, 16'h0000, 16'h5555}, 3'd6, 8'h00, 4'd8);
        // full brake
        send_report({16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000}, 3'd6, 8'h00, 4'd8);
        // reverse button out of range: gear invalid, linear zero
        send_report({16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF}, 3'd6, 8'h00, 4'd3);
        // braking in invalid gear zeroes linear; both gear buttons down
        send_report({16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h7FFF}, 3'd6, 8'h09, 4'd8);
        // both released from invalid: forward wins
        send_report({16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h3000}, 3'd6, 8'h00, 4'd8);
        // from forward, a double release only counts the reverse one
        send_report({16'h0000, 16'h0000, 16'h8000, 16'h6000, 16'h0000, 16'h3000}, 3'd6, 8'h09, 4'd8);
        send_report({16'h0000, 16'h0000, 16'h8000, 16'h6000, 16'h0000, 16'h3000}, 3'd6, 8'h00, 4'd8);
        // no valid axes at all
        send_report({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 3'd0, 8'h01, 4'd8);
        // axis count past the field count
        send_report({16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 3'd7, 8'h00, 4'd8);
        // brake axis past the valid count: no brake
        send_report({16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h8001}, 3'd3, 8'h08, 4'd8);
        // button count past the field count, every button down
        send_report({16'h0000, 16'h0000, 16'h8000, 16'h2000, 16'h0000, 16'h7FFE}, 3'd6, 8'hFF, 4'd15);
        // no valid buttons
        send_report({16'h0000, 16'h0000, 16'h8000, 16'h2000, 16'h0000, 16'h7FFE}, 3'd6, 8'h00, 4'd0);
        // turbo button down while turbo is not allowed
        send_report({16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001}, 3'd6, 8'h03, 4'd8);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // ---- directed, all gains at maximum, turbo on button 7, deadman needed
        // steer a4, deadman a5, throttle a0, brake a1
        c = '{axis_map: 12'd556, turbo_button: 3'd7, linear_scale: 16'hFFFF,
              angular_scale: 16'hFFFF, turbo_scale: 12'hFFF, turbo_allowed: 1'b1,
              deadman_required: 1'b1};
        apply_cfg(c);
        // deadman pedal fully up: commands zeroed
        send_report({16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF}, 3'd6, 8'h81, 4'd8);
        // deadman barely pressed, largest turbo product
        send_report({16'h8001, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF}, 3'd6, 8'h81, 4'd8);
        send_report({16'h8001, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF}, 3'd6, 8'h80, 4'd8);
        // turbo button just out of range
        send_report({16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF}, 3'd6, 8'h80, 4'd7);
        // deadman axis out of range: gate closes
        send_report({16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF}, 3'd5, 8'h80, 4'd8);
        // brake on the largest held speed
        send_report({16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF}, 3'd6, 8'h80, 4'd8);
        send_report({16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h7FFF}, 3'd6, 8'h80, 4'd8);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // ---- random phases, each with its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                // every gain and flag at its top
                c = '1;
                c.axis_map = rand_axis_map();
            end else if (p == 1) begin
                // all selectors on axis 0, zero gains, flags off
                c = '0;
            end else begin
                c.axis_map         = rand_axis_map();
                c.turbo_button     = 3'($urandom);
                c.linear_scale     = rand_gain(16);
                c.angular_scale    = rand_gain(16);
                c.turbo_scale      = 12'(rand_gain(12));
                c.turbo_allowed    = 1'($urandom);
                c.deadman_required = 1'($urandom);
            end
            apply_cfg(c);
            // one quiet phase mid-run and the whole last phase run without idling
            if (p == 5 || p == RANDOM_PHASES - 1)
                gaps_on <= 1'b0;
            else
                gaps_on <= 1'b1;
            // receiver stalls long enough for the block to back up its input
            if (p == 3) begin
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_report();
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        // let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending_cmds.size() != 0)
            sb.report_mismatch($sformatf("%0d commands never arrived", sb.pending_cmds.size()));
        if (sb.mismatches == 0)
            $display("wheel_pedal_drive_command_mapper_top_tb: PASS");
        else
            $display("wheel_pedal_drive_command_mapper_top_tb: FAIL");
        $finish;
    end

endmodule
